// ===== rtl/cpss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpss_pkg
// Shared types, codes and tables of the charlieplexed seven-segment scanner.
// ----------------------------------------------------------------------------
package cpss_pkg;

    localparam int unsigned SEG_COUNT = 23;
    localparam logic [4:0] SEG_NONE = 5'd23;
    localparam logic [4:0] SEG_LAST = 5'd22;
    localparam logic [3:0] BLANK_DIGIT = 4'd10;
    localparam logic [15:0] HOLD_RESET = 16'd800;
    localparam logic [6:0] TEMP_CLAMP = 7'd99;
    localparam logic signed [15:0] TEMP_LIMIT = 16'sd990;

    localparam logic [1:0] FUNC_SET_DIGITS = 2'd0;
    localparam logic [1:0] FUNC_SET_TEMP = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    typedef struct packed {
        logic [3:0] mid;
        logic [3:0] lo;
    } temp_digits_t;

    typedef struct packed {
        logic [5:0] pin_enable;
        logic [5:0] pin_level;
        logic [4:0] segment_now;
        logic       frame_end;
    } drive_t;

    function automatic logic [6:0] glyph(input logic [3:0] v);
        logic [6:0] g;
        case (v)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    // anode in [5:3], cathode in [2:0]
    function automatic logic [5:0] pin_pair(input logic [4:0] seg);
        logic [5:0] p;
        case (seg)
            5'd0:    p = {3'd1, 3'd0};
            5'd1:    p = {3'd2, 3'd0};
            5'd2:    p = {3'd3, 3'd0};
            5'd3:    p = {3'd4, 3'd1};
            5'd4:    p = {3'd3, 3'd1};
            5'd5:    p = {3'd2, 3'd1};
            5'd6:    p = {3'd0, 3'd1};
            5'd7:    p = {3'd4, 3'd0};
            5'd8:    p = {3'd0, 3'd2};
            5'd9:    p = {3'd1, 3'd2};
            5'd10:   p = {3'd3, 3'd2};
            5'd11:   p = {3'd4, 3'd3};
            5'd12:   p = {3'd2, 3'd3};
            5'd13:   p = {3'd1, 3'd3};
            5'd14:   p = {3'd0, 3'd3};
            5'd15:   p = {3'd4, 3'd2};
            5'd16:   p = {3'd0, 3'd4};
            5'd17:   p = {3'd1, 3'd4};
            5'd18:   p = {3'd2, 3'd4};
            5'd19:   p = {3'd3, 3'd5};
            5'd20:   p = {3'd2, 3'd5};
            5'd21:   p = {3'd1, 3'd5};
            5'd22:   p = {3'd0, 3'd5};
            default: p = 6'd0;
        endcase
        return p;
    endfunction

    function automatic drive_t seg_drive(input logic [4:0] seg, input logic fend);
        drive_t     d;
        logic [5:0] p;
        p = pin_pair(seg);
        d.frame_end = fend;
        if (seg <= SEG_LAST) begin
            d.pin_level   = 6'b1 << p[5:3];
            d.pin_enable  = (6'b1 << p[5:3]) | (6'b1 << p[2:0]);
            d.segment_now = seg;
        end else begin
            d.pin_level   = 6'd0;
            d.pin_enable  = 6'd0;
            d.segment_now = SEG_NONE;
        end
        return d;
    endfunction

endpackage

// ===== rtl/charlieplex_seven_segment_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charlieplex_seven_segment_scanner
// Six-pin charlieplexed driver for three digits and two dots, 23 segments.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_ready is high and returns one result beat
// per input beat; an accepted beat passes through the input register and is
// then registered in the result register once the output side is free.
// Each beat is processed combinationally between the input register and the
// result register; the next lit segment comes from a priority encoder over
// the 23-segment mask. While a finished result waits, one more beat is
// taken into the empty input register and then the input stalls until the
// result is taken. hold_ticks is written through cfg_wr_en / cfg_wr_data
// only while no beat is in flight by the user; the block does not enforce it.
// ----------------------------------------------------------------------------
module charlieplex_seven_segment_scanner (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [3:0]         digit_hi,
    input  logic [3:0]         digit_mid,
    input  logic [3:0]         digit_lo,
    input  logic               point_one,
    input  logic               point_two,
    input  logic signed [15:0] temp_tenths,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         pin_enable,
    output logic [5:0]         pin_level,
    output logic [4:0]         segment_now,
    output logic               frame_end
);

    logic               hold_ticks_reg;
    logic [15:0]        hold_value_reg;
    logic               in_valid_reg;
    logic [1:0]         func_reg;
    logic [3:0]         digit_hi_reg;
    logic [3:0]         digit_mid_reg;
    logic [3:0]         digit_lo_reg;
    logic               point_one_reg;
    logic               point_two_reg;
    logic signed [15:0] temp_tenths_reg;
    logic               out_valid_reg, out_valid_next;
    cpss_pkg::drive_t   drive_reg;

    logic                   work;
    cpss_pkg::temp_digits_t temp_digits;
    cpss_pkg::drive_t       drive;

    assign work     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || work;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_ticks_reg <= 1'b0;
            hold_value_reg <= cpss_pkg::HOLD_RESET;
        end else if (cfg_wr_en) begin
            hold_ticks_reg <= 1'b1;
            hold_value_reg <= cfg_wr_data;
        end
    end

    // hold the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            func_reg        <= func;
            digit_hi_reg    <= digit_hi;
            digit_mid_reg   <= digit_mid;
            digit_lo_reg    <= digit_lo;
            point_one_reg   <= point_one;
            point_two_reg   <= point_two;
            temp_tenths_reg <= temp_tenths;
        end
    end

    cpss_temp u_temp (
        .temp_tenths (temp_tenths_reg),
        .digits      (temp_digits)
    );

    cpss_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (work),
        .func        (func_reg),
        .digit_hi    (digit_hi_reg),
        .digit_mid   (digit_mid_reg),
        .digit_lo    (digit_lo_reg),
        .point_one   (point_one_reg),
        .point_two   (point_two_reg),
        .temp_digits (temp_digits),
        .hold_ticks  (hold_value_reg),
        .drive       (drive)
    );

    assign out_valid_next = work || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work) begin
            drive_reg <= drive;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pin_enable  = drive_reg.pin_enable;
    assign pin_level   = drive_reg.pin_level;
    assign segment_now = drive_reg.segment_now;
    assign frame_end   = drive_reg.frame_end;

    a_frame_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && drive_reg.frame_end) |->
            ((drive_reg.pin_enable == 6'd0) && (drive_reg.segment_now == cpss_pkg::SEG_NONE)))
        else $error("frame end beat with pins driven");

    a_two_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (($countones(drive_reg.pin_enable) == 2)
            || (drive_reg.segment_now == cpss_pkg::SEG_NONE)))
        else $error("driven segment without exactly two pins");

    a_level_in_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hold_ticks_reg) |->
            ((drive_reg.pin_level & ~drive_reg.pin_enable) == 6'd0))
        else $error("level high on an undriven pin");

endmodule

// ===== rtl/cpss_temp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpss_temp
// Converts tenths of a degree into tens and units digits with leading blank.
// ----------------------------------------------------------------------------
module cpss_temp (
    input  logic signed [15:0]    temp_tenths,
    output cpss_pkg::temp_digits_t digits
);

    logic        in_range;
    logic [16:0] sum;
    logic [16:0] sum_abs;
    logic [9:0]  mag;
    logic [17:0] prod;
    logic [6:0]  quot;
    logic [6:0]  whole;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  units;

    assign in_range = (temp_tenths >= -cpss_pkg::TEMP_LIMIT)
                   && (temp_tenths <= cpss_pkg::TEMP_LIMIT);

    assign sum     = {temp_tenths[15], temp_tenths} + 17'd5;
    assign sum_abs = sum[16] ? (~sum + 17'd1) : sum;
    assign mag     = sum_abs[9:0];

    // divide by ten, exact for values below 1029
    assign prod  = {8'd0, mag} * 18'd205;
    assign quot  = prod[17:11];
    assign whole = (quot > cpss_pkg::TEMP_CLAMP) ? cpss_pkg::TEMP_CLAMP : quot;

    always_comb
    begin
        tens = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (whole >= 7'(10 * k)) begin
                tens = 4'(k);
            end
        end
    end

    assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    assign units    = whole - tens_x10;

    always_comb
    begin
        if (!in_range) begin
            digits.mid = cpss_pkg::BLANK_DIGIT;
            digits.lo  = cpss_pkg::BLANK_DIGIT;
        end else begin
            digits.mid = (tens == 4'd0) ? cpss_pkg::BLANK_DIGIT : tens;
            digits.lo  = units[3:0];
        end
    end

endmodule

// ===== rtl/cpss_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpss_scan
// Display state and scan sequencer; one item processed per cycle while step is high.
// ----------------------------------------------------------------------------
module cpss_scan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [1:0]             func,
    input  logic [3:0]             digit_hi,
    input  logic [3:0]             digit_mid,
    input  logic [3:0]             digit_lo,
    input  logic                   point_one,
    input  logic                   point_two,
    input  cpss_pkg::temp_digits_t temp_digits,
    input  logic [15:0]            hold_ticks,
    output cpss_pkg::drive_t       drive
);

    logic [3:0]  digit_hi_reg, digit_hi_next;
    logic [3:0]  digit_mid_reg, digit_mid_next;
    logic [3:0]  digit_lo_reg, digit_lo_next;
    logic        dot_one_reg, dot_one_next;
    logic        dot_two_reg, dot_two_next;
    logic [4:0]  scan_index_reg, scan_index_next;
    logic [15:0] hold_left_reg, hold_left_next;

    logic [22:0] lit_mask;
    logic [22:0] cand;
    logic [4:0]  start;
    logic [4:0]  found_seg;
    logic        found;
    logic [15:0] hold_len;

    assign lit_mask = {cpss_pkg::glyph(digit_lo_reg), dot_two_reg,
                       cpss_pkg::glyph(digit_mid_reg), dot_one_reg,
                       cpss_pkg::glyph(digit_hi_reg)};

    assign start = (scan_index_reg > cpss_pkg::SEG_LAST) ? 5'd0 : scan_index_reg + 5'd1;

    always_comb
    begin
        for (int i = 0; i < cpss_pkg::SEG_COUNT; i++) begin
            cand[i] = lit_mask[i] && (5'(i) >= start);
        end
    end

    always_comb
    begin
        found_seg = cpss_pkg::SEG_NONE;
        for (int i = cpss_pkg::SEG_COUNT - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found_seg = 5'(i);
            end
        end
    end

    assign found    = |cand;
    assign hold_len = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;

    always_comb
    begin
        digit_hi_next   = digit_hi_reg;
        digit_mid_next  = digit_mid_reg;
        digit_lo_next   = digit_lo_reg;
        dot_one_next    = dot_one_reg;
        dot_two_next    = dot_two_reg;
        scan_index_next = scan_index_reg;
        hold_left_next  = hold_left_reg;
        drive           = cpss_pkg::seg_drive(scan_index_reg, 1'b0);
        case (func)
            cpss_pkg::FUNC_TICK:
            begin
                if ((scan_index_reg <= cpss_pkg::SEG_LAST) && (hold_left_reg != 16'd0)) begin
                    hold_left_next = hold_left_reg - 16'd1;
                end else if (found) begin
                    scan_index_next = found_seg;
                    hold_left_next  = hold_len - 16'd1;
                    drive           = cpss_pkg::seg_drive(found_seg, 1'b0);
                end else begin
                    scan_index_next = cpss_pkg::SEG_NONE;
                    hold_left_next  = 16'd0;
                    drive           = cpss_pkg::seg_drive(cpss_pkg::SEG_NONE, 1'b1);
                end
            end
            cpss_pkg::FUNC_SET_DIGITS:
            begin
                if (digit_hi <= cpss_pkg::BLANK_DIGIT) begin
                    digit_hi_next = digit_hi;
                end
                if (digit_mid <= cpss_pkg::BLANK_DIGIT) begin
                    digit_mid_next = digit_mid;
                end
                if (digit_lo <= cpss_pkg::BLANK_DIGIT) begin
                    digit_lo_next = digit_lo;
                end
                dot_one_next = point_one;
                dot_two_next = point_two;
            end
            cpss_pkg::FUNC_SET_TEMP:
            begin
                digit_hi_next  = cpss_pkg::BLANK_DIGIT;
                digit_mid_next = temp_digits.mid;
                digit_lo_next  = temp_digits.lo;
                dot_one_next   = 1'b1;
                dot_two_next   = 1'b0;
            end
            default:
            begin
                scan_index_next = scan_index_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            digit_hi_reg   <= cpss_pkg::BLANK_DIGIT;
            digit_mid_reg  <= cpss_pkg::BLANK_DIGIT;
            digit_lo_reg   <= cpss_pkg::BLANK_DIGIT;
            dot_one_reg    <= 1'b0;
            dot_two_reg    <= 1'b0;
            scan_index_reg <= cpss_pkg::SEG_NONE;
            hold_left_reg  <= 16'd0;
        end else if (step) begin
            digit_hi_reg   <= digit_hi_next;
            digit_mid_reg  <= digit_mid_next;
            digit_lo_reg   <= digit_lo_next;
            dot_one_reg    <= dot_one_next;
            dot_two_reg    <= dot_two_next;
            scan_index_reg <= scan_index_next;
            hold_left_reg  <= hold_left_next;
        end
    end

    a_hold_needs_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_left_reg != 16'd0) |-> (scan_index_reg <= cpss_pkg::SEG_LAST))
        else $error("hold count running with no segment selected");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_index_reg <= cpss_pkg::SEG_NONE)
        else $error("scan index out of range");

endmodule
